FILE: hdl/wfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_pkg
// shared constants, types and codes of the windowed median filter
// ----------------------------------------------------------------------------
package wfm_pkg;

  localparam int MAX_WINDOW  = 9;
  localparam int MAX_COLS    = 2048;
  localparam int PIXEL_BITS  = 16;
  localparam int ROW_LIMIT   = 4096;

  localparam int STORE_ROWS  = MAX_WINDOW + 1;
  localparam int SLOT_W      = $clog2(STORE_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(ROW_LIMIT);
  localparam int STORE_DEPTH = STORE_ROWS * MAX_COLS;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int NUM_CELLS   = MAX_WINDOW * MAX_WINDOW;
  localparam int CNT_W       = $clog2(NUM_CELLS + 1);
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
  localparam int OFS_W       = WIN_W + 1;

  localparam logic [1:0] SHAPE_RECT  = 2'd0;
  localparam logic [1:0] SHAPE_CROSS = 2'd1;
  localparam logic [1:0] SHAPE_X     = 2'd2;

  typedef enum logic [2:0] {
    REG_SHAPE  = 3'd0,
    REG_WROWS  = 3'd1,
    REG_WCOLS  = 3'd2,
    REG_IROWS  = 3'd3,
    REG_ICOLS  = 3'd4
  } reg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_SELECT = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shl;
  } cell_ctl_t;

endpackage

FILE: hdl/windowed_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_median_filter
// streaming 2-d median filter over rectangle, cross or x shaped windows
// ----------------------------------------------------------------------------
// one input beat is accepted in the idle state, then checked; when a result is due,
// its window positions are walked through the single line store read port, the
// kept samples are sorted, and the median is shifted to the head and emitted
// before the next beat is accepted
// reset clears positions, registers go to shape 0, 3x3 window, 512x512 image
// line store contents are undefined after reset
module windowed_median_filter
  import wfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIXEL_BITS-1:0] s_axis_tdata,  // pixel_in
  input  logic                  s_axis_tuser,  // flush
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // median_out
  output logic                  m_axis_tlast,  // end_of_row
  output logic                  m_axis_tuser,  // end_of_frame
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration
  logic [1:0]  shape_q;
  logic [3:0]  wrows_q, wcols_q;
  logic [12:0] irows_q;
  logic [11:0] icols_q;
  reg_idx_e    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_RECT;
      wrows_q <= 4'd3;
      wcols_q <= 4'd3;
      irows_q <= 13'd512;
      icols_q <= 12'd512;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_SHAPE: shape_q <= pwdata[1:0];
        REG_WROWS: wrows_q <= pwdata[3:0];
        REG_WCOLS: wcols_q <= pwdata[3:0];
        REG_IROWS: irows_q <= pwdata[12:0];
        REG_ICOLS: icols_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_SHAPE: prdata = {30'd0, shape_q};
        REG_WROWS: prdata = {28'd0, wrows_q};
        REG_WCOLS: prdata = {28'd0, wcols_q};
        REG_IROWS: prdata = {19'd0, irows_q};
        REG_ICOLS: prdata = {20'd0, icols_q};
        default:   prdata = '0;
      endcase
    end
  end

  // clamped geometry
  logic [3:0]  wr, wc, ar, br, ac, bc, hc;
  logic [12:0] nrows;
  logic [11:0] ncols;

  always_comb begin
    wr = (wrows_q == 4'd0) ? 4'd1 : (wrows_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : wrows_q;
    wc = (wcols_q == 4'd0) ? 4'd1 : (wcols_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : wcols_q;
    nrows = (irows_q == 13'd0) ? 13'd1 :
            (irows_q > 13'(ROW_LIMIT)) ? 13'(ROW_LIMIT) : irows_q;
    ncols = (icols_q == 12'd0) ? 12'd1 :
            (icols_q > 12'(MAX_COLS)) ? 12'(MAX_COLS) : icols_q;
    ar = (wr - 4'd1) >> 1;
    br = wr >> 1;
    ac = (wc - 4'd1) >> 1;
    bc = wc >> 1;
    hc = (shape_q == SHAPE_X) ? br : bc;
  end

  // positions
  state_e              state_q;
  logic [ROW_W-1:0]    irow_q, orow_q;
  logic [COL_W-1:0]    icol_q, ocol_q;
  logic [SLOT_W-1:0]   islot_q, oslot_q;
  logic                done_q;
  logic                in_beat, out_load;
  logic                icol_wrap, irow_wrap, eor, eof, ready;
  logic [12:0]         need_r;
  logic [11:0]         need_c;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign icol_wrap     = ({1'b0, icol_q} + 12'd1) >= ncols;
  assign irow_wrap     = ({1'b0, irow_q} + 13'd1) >= nrows;
  assign eor           = ({1'b0, ocol_q} + 12'd1) >= ncols;
  assign eof           = eor && (({1'b0, orow_q} + 13'd1) >= nrows);

  always_comb begin
    need_r = {1'b0, orow_q} + 13'(br);
    if (need_r > nrows - 13'd1) need_r = nrows - 13'd1;
    need_c = {1'b0, ocol_q} + 12'(hc);
    if (need_c > ncols - 12'd1) need_c = ncols - 12'd1;
    ready = done_q || ({1'b0, irow_q} > need_r) ||
            (({1'b0, irow_q} == need_r) && ({1'b0, icol_q} > need_c));
  end

  // window walk
  logic signed [OFS_W-1:0] d1_q, d2_q, dr, dc, neg_ar, neg_ac;
  logic                    pass_q, skip, last;
  logic signed [ROW_W+1:0] r_pos;
  logic signed [COL_W+1:0] c_pos;
  logic signed [SLOT_W+1:0] slot;
  logic                    take;
  logic [CNT_W-1:0]        n_q, rank_q;
  logic                    rd_vld_q;
  logic [ADDR_W-1:0]       raddr, waddr;
  logic [PIXEL_BITS-1:0]   rdata, head;
  cell_ctl_t               ctl;

  assign neg_ar = -$signed({1'b0, ar});
  assign neg_ac = -$signed({1'b0, ac});

  always_comb begin
    dr   = d1_q;
    dc   = d2_q;
    skip = 1'b0;
    last = (d1_q == $signed({1'b0, br})) && (d2_q == $signed({1'b0, bc}));
    case (shape_q)
      SHAPE_CROSS: begin
        dr   = pass_q ? '0 : d1_q;
        dc   = pass_q ? d2_q : '0;
        skip = pass_q && (d2_q == '0);
        last = pass_q && (d2_q == $signed({1'b0, bc}));
      end
      SHAPE_X: begin
        dr   = d1_q;
        dc   = pass_q ? -d1_q : d1_q;
        skip = pass_q && (d1_q == '0);
        last = pass_q && (d1_q == $signed({1'b0, br}));
      end
      default: ;
    endcase
    r_pos = $signed({2'b00, orow_q}) + (ROW_W + 2)'(dr);
    c_pos = $signed({2'b00, ocol_q}) + (COL_W + 2)'(dc);
    take  = !skip && !r_pos[ROW_W+1] && !c_pos[COL_W+1] &&
            (r_pos < $signed({1'b0, nrows})) && (c_pos < $signed({1'b0, ncols}));
    slot  = $signed({2'b00, oslot_q}) + (SLOT_W + 2)'(dr);
    if (slot < 0) begin
      slot = slot + (SLOT_W + 2)'(STORE_ROWS);
    end else if (slot >= (SLOT_W + 2)'(STORE_ROWS)) begin
      slot = slot - (SLOT_W + 2)'(STORE_ROWS);
    end
    raddr = {slot[SLOT_W-1:0], c_pos[COL_W-1:0]};
    waddr = {islot_q, icol_q};
  end

  wfm_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_ROWS * MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_beat && !s_axis_tuser && !done_q),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (state_q == S_SCAN && take),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    ctl.clr = (state_q == S_CHECK);
    ctl.ins = rd_vld_q;
    ctl.shl = (state_q == S_SELECT) && (rank_q != '0);
  end

  wfm_sorter u_sorter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (rdata),
    .head_o (head)
  );

  assign out_load = (state_q == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      irow_q   <= '0;
      icol_q   <= '0;
      islot_q  <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
      oslot_q  <= '0;
      done_q   <= 1'b0;
      d1_q     <= '0;
      d2_q     <= '0;
      pass_q   <= 1'b0;
      n_q      <= '0;
      rank_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN) && take;
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            if (!s_axis_tuser && !done_q) begin
              if (icol_wrap) begin
                icol_q <= '0;
                if (irow_wrap) begin
                  irow_q  <= '0;
                  islot_q <= '0;
                  done_q  <= 1'b1;
                end else begin
                  irow_q  <= irow_q + ROW_W'(1);
                  islot_q <= (islot_q == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                   : islot_q + SLOT_W'(1);
                end
              end else begin
                icol_q <= icol_q + COL_W'(1);
              end
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          d1_q    <= neg_ar;
          d2_q    <= neg_ac;
          pass_q  <= 1'b0;
          n_q     <= '0;
          state_q <= ready ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (take) n_q <= n_q + CNT_W'(1);
          case (shape_q)
            SHAPE_CROSS: begin
              if (!pass_q) begin
                if (d1_q == $signed({1'b0, br})) pass_q <= 1'b1;
                else d1_q <= d1_q + OFS_W'(1);
              end else begin
                d2_q <= d2_q + OFS_W'(1);
              end
            end
            SHAPE_X: begin
              if (!pass_q && d1_q == $signed({1'b0, br})) begin
                pass_q <= 1'b1;
                d1_q   <= neg_ar;
              end else begin
                d1_q <= d1_q + OFS_W'(1);
              end
            end
            default: begin
              if (d2_q == $signed({1'b0, bc})) begin
                d2_q <= neg_ac;
                d1_q <= d1_q + OFS_W'(1);
              end else begin
                d2_q <= d2_q + OFS_W'(1);
              end
            end
          endcase
          if (last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          rank_q  <= (n_q == '0) ? '0 : (n_q - CNT_W'(1)) >> 1;
          state_q <= S_SELECT;
        end
        S_SELECT: begin
          if (rank_q == '0) state_q <= S_EMIT;
          else rank_q <= rank_q - CNT_W'(1);
        end
        S_EMIT: begin
          if (out_load) begin
            if (eof) begin
              orow_q  <= '0;
              ocol_q  <= '0;
              oslot_q <= '0;
              done_q  <= 1'b0;
            end else if (eor) begin
              ocol_q  <= '0;
              orow_q  <= orow_q + ROW_W'(1);
              oslot_q <= (oslot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : oslot_q + SLOT_W'(1);
            end else begin
              ocol_q <= ocol_q + COL_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register
  logic        out_vld_q;
  logic [15:0] out_data_q;
  logic        out_eor_q, out_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= (n_q == '0) ? 16'd0 : 16'(head);
      out_eor_q  <= eor;
      out_eof_q  <= eof;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_eor_q;
  assign m_axis_tuser  = out_eof_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(NUM_CELLS))
    else $error("sample count beyond sorter length");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_insert_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == S_SCAN)
    else $error("sorter insert without a line store read");

  a_eof_has_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without row end");

endmodule

FILE: hdl/wfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module wfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/wfm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_cell
// one slot of the insertion sorting chain
// ----------------------------------------------------------------------------
module wfm_cell
  import wfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctl_t             ctl_i,
  input  logic [PIXEL_BITS-1:0] x_i,
  input  logic [PIXEL_BITS-1:0] left_v_i,
  input  logic                  left_vld_i,
  input  logic                  left_gt_i,
  input  logic [PIXEL_BITS-1:0] right_v_i,
  input  logic                  right_vld_i,
  output logic [PIXEL_BITS-1:0] v_o,
  output logic                  vld_o,
  output logic                  gt_o
);

  logic [PIXEL_BITS-1:0] v_q;
  logic                  vld_q;

  // empty slots count as larger than any sample
  assign gt_o  = !vld_q || (x_i < v_q);
  assign v_o   = v_q;
  assign vld_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clr) begin
      vld_q <= 1'b0;
    end else if (ctl_i.ins && gt_o) begin
      vld_q <= left_gt_i ? left_vld_i : 1'b1;
    end else if (ctl_i.shl) begin
      vld_q <= right_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && gt_o) begin
      v_q <= left_gt_i ? left_v_i : x_i;
    end else if (ctl_i.shl) begin
      v_q <= right_v_i;
    end
  end

endmodule

FILE: hdl/wfm_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_sorter
// chain of cells kept in ascending order, shifts toward the head on demand
// ----------------------------------------------------------------------------
module wfm_sorter
  import wfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctl_t             ctl_i,
  input  logic [PIXEL_BITS-1:0] x_i,
  output logic [PIXEL_BITS-1:0] head_o
);

  logic [PIXEL_BITS-1:0] v   [NUM_CELLS];
  logic                  vld [NUM_CELLS];
  logic                  gt  [NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [PIXEL_BITS-1:0] lv, rv;
    logic                  lvld, lgt, rvld;
    if (i == 0) begin : g_head
      assign lv   = '0;
      assign lvld = 1'b0;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lv   = v[i-1];
      assign lvld = vld[i-1];
      assign lgt  = gt[i-1];
    end
    if (i == NUM_CELLS - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rv   = v[i+1];
      assign rvld = vld[i+1];
    end
    wfm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .x_i         (x_i),
      .left_v_i    (lv),
      .left_vld_i  (lvld),
      .left_gt_i   (lgt),
      .right_v_i   (rv),
      .right_vld_i (rvld),
      .v_o         (v[i]),
      .vld_o       (vld[i]),
      .gt_o        (gt[i])
    );
  end

  assign head_o = v[0];

endmodule

FILE: tb/sv/windowed_median_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_median_filter_tb
// Self-checking bench for the streaming median filter. Whole frames are
// streamed under many window shapes, extents and image sizes, and each is
// drained with flush beats. A scoreboard keeps its own line store, positions
// and register copies, predicts every result beat and checks median, end of
// row and end of frame. Both stream sides idle at random. Registers are
// written over APB only while the block is idle.
// ----------------------------------------------------------------------------
import wfm_pkg::*;

typedef struct {
  logic [15:0] median;
  logic        eor;
  logic        eof;
} median_beat_t;

class median_scoreboard;
  logic [15:0]  line_mem [STORE_DEPTH];
  int unsigned  in_row, in_col, out_row, out_col;
  bit           in_done;
  logic [1:0]   shape;
  logic [3:0]   wrows, wcols;
  logic [12:0]  irows;
  logic [11:0]  icols;
  int unsigned  picks [$];
  median_beat_t pending [$];
  int           errors;

  function new();
    foreach (line_mem[i]) line_mem[i] = '0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0; in_done = 0;
    shape = SHAPE_RECT; wrows = 3; wcols = 3; irows = 512; icols = 512;
    errors = 0;
  endfunction

  function int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void set_reg(reg_idx_e idx, logic [31:0] val);
    case (idx)
      REG_SHAPE: shape = val[1:0];
      REG_WROWS: wrows = val[3:0];
      REG_WCOLS: wcols = val[3:0];
      REG_IROWS: irows = val[12:0];
      REG_ICOLS: icols = val[11:0];
      default: ;
    endcase
  endfunction

  function bit frame_idle();
    return !in_done && in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
  endfunction

  function void grab(int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return;
    picks.push_back(line_mem[(r % STORE_ROWS) * MAX_COLS + (c % MAX_COLS)]);
  endfunction

  function logic [15:0] median_at(int r, int c, int nr, int nc);
    int wr, wc, ar, br, ac, bc, j;
    int unsigned v;
    wr = clampv(wrows, MAX_WINDOW);
    wc = clampv(wcols, MAX_WINDOW);
    ar = (wr - 1) / 2; br = wr / 2;
    ac = (wc - 1) / 2; bc = wc / 2;
    picks.delete();
    if (shape == SHAPE_CROSS) begin
      for (int d = -ar; d <= br; d++) grab(r + d, c, nr, nc);
      for (int d = -ac; d <= bc; d++) if (d != 0) grab(r, c + d, nr, nc);
    end else if (shape == SHAPE_X) begin
      for (int d = -ar; d <= br; d++) grab(r + d, c + d, nr, nc);
      for (int d = -ar; d <= br; d++) if (d != 0) grab(r + d, c - d, nr, nc);
    end else begin
      for (int d = -ar; d <= br; d++)
        for (int e = -ac; e <= bc; e++) grab(r + d, c + e, nr, nc);
    end
    if (picks.size() == 0) return '0;
    for (int i = 1; i < picks.size(); i++) begin
      v = picks[i];
      j = i;
      while (j > 0 && picks[j-1] > v) begin
        picks[j] = picks[j-1];
        j--;
      end
      picks[j] = v;
    end
    return 16'(picks[(picks.size() - 1) / 2]);
  endfunction

  function void note_beat(logic [15:0] pix, logic flush);
    int unsigned nr, nc, hr, hc, need_r, need_c;
    median_beat_t b;
    nr = clampv(irows, ROW_LIMIT);
    nc = clampv(icols, MAX_COLS);
    hr = clampv(wrows, MAX_WINDOW) / 2;
    hc = (shape == SHAPE_X) ? hr : clampv(wcols, MAX_WINDOW) / 2;
    if (!flush && !in_done) begin
      line_mem[(in_row % STORE_ROWS) * MAX_COLS + (in_col % MAX_COLS)] = pix;
      in_col++;
      if (in_col >= nc) begin
        in_col = 0;
        in_row++;
        if (in_row >= nr) begin
          in_row = 0;
          in_done = 1;
        end
      end
    end
    need_r = (out_row + hr > nr - 1) ? nr - 1 : out_row + hr;
    need_c = (out_col + hc > nc - 1) ? nc - 1 : out_col + hc;
    if (!(in_done || in_row > need_r || (in_row == need_r && in_col > need_c))) return;
    b.median = median_at(out_row, out_col, nr, nc);
    b.eor = (out_col + 1 >= nc);
    b.eof = b.eor && (out_row + 1 >= nr);
    if (b.eof) begin
      out_row = 0; out_col = 0; in_done = 0;
    end else if (b.eor) begin
      out_col = 0; out_row++;
    end else begin
      out_col++;
    end
    pending.push_back(b);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task check_beat(logic [15:0] med, logic eor, logic eof);
    median_beat_t b;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result beat median=%h", med));
      return;
    end
    b = pending.pop_front();
    if (med !== b.median) report($sformatf("median %h, want %h", med, b.median));
    if (eor !== b.eor) report($sformatf("end of row %b, want %b", eor, b.eor));
    if (eof !== b.eof) report($sformatf("end of frame %b, want %b", eof, b.eof));
  endtask
endclass

module windowed_median_filter_tb;
  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [PIXEL_BITS-1:0] s_axis_tdata = '0;  // pixel_in
  logic                  s_axis_tuser = 0;   // flush
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [15:0]           m_axis_tdata;       // median_out
  logic                  m_axis_tlast;       // end_of_row
  logic                  m_axis_tuser;       // end_of_frame
  logic                  psel = 0;
  logic                  penable = 0;
  logic                  pwrite = 0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  median_scoreboard sb = new();
  int  beats_sent = 0;
  bit  calm = 0;
  int  quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  windowed_median_filter u_top (.*);

  // result side with random stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // watchdog on cycles without any stream beat or APB access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("** windowed_median_filter: FAILED **");
      $finish;
    end
  end

  task send_beat(logic [15:0] pix, logic flush);
    if (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= flush;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(pix, flush);
    beats_sent++;
    calm = (beats_sent > 700 && beats_sent < 1000);
  endtask

  task wait_drained();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    sb.set_reg(idx, val);
  endtask

  function logic [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task run_frame(int shp, int wr, int wc, int ir, int ic);
    int unsigned npix;
    wait_drained();
    write_reg(REG_SHAPE, shp);
    write_reg(REG_WROWS, wr);
    write_reg(REG_WCOLS, wc);
    write_reg(REG_IROWS, ir);
    write_reg(REG_ICOLS, ic);
    npix = sb.clampv(ir[12:0], ROW_LIMIT) * sb.clampv(ic[11:0], MAX_COLS);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < 5) send_beat(16'($urandom), 1);
      send_beat(pick_pixel(), 0);
    end
    // drain the owed rows, with some dropped pixels mixed in
    while (!sb.frame_idle()) begin
      if ($urandom_range(0, 3) == 0) send_beat(16'($urandom), 0);
      else send_beat(16'($urandom), 1);
    end
  endtask

  initial begin
    int ir, ic;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    run_frame(SHAPE_RECT, 3, 3, 2, 2);
    run_frame(SHAPE_CROSS, 9, 9, 3, 4);
    run_frame(SHAPE_X, 4, 2, 3, 3);
    run_frame(3, 0, 15, 2, 3);
    run_frame(SHAPE_RECT, 15, 0, 0, 0);
    run_frame(SHAPE_X, 9, 1, 2, 2);
    while (beats_sent < 1950) begin
      ir = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 8);
      ic = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 9);
      run_frame($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                ir, ic);
    end
    wait_drained();
    if (sb.errors == 0)
      $display("** windowed_median_filter: PASSED **");
    else
      $display("** windowed_median_filter: FAILED **");
    $finish;
  end
endmodule
